### rtl/core/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int CELL_W    = 7;
  localparam int SIZE_W    = 7;
  localparam int TRACE_W   = 13;
  localparam int COUNT_W   = 7;
  localparam int BITMAP_W  = 64;
  localparam int BIT_IDX_W = 6;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [TRACE_W-1:0]  trace_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [BITMAP_W-1:0] bitmap_t;

  // per-cell position flags carried from the input register into the update stage
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic on_diag;
    logic last_row;
    logic end_row;
    logic end_mat;
  } cell_ctl_t;

endpackage

### rtl/core/lsc_if.sv
`timescale 1ns / 1ps

interface lsc_in_if;
  import lsc_pkg::*;
  logic  valid;
  logic  ready;
  cell_t cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface lsc_out_if;
  import lsc_pkg::*;
  logic   valid;
  logic   ready;
  trace_t trace_sum;
  count_t bad_row_count;
  count_t bad_column_count;
  modport source (output valid, output trace_sum, output bad_row_count,
                  output bad_column_count, input ready);
  modport sink (input valid, input trace_sum, input bad_row_count,
                input bad_column_count, output ready);
endinterface

interface lsc_cfg_if;
  import lsc_pkg::*;
  logic  valid;
  logic  ready;
  size_t matrix_size;
  modport source (output valid, output matrix_size, input ready);
  modport sink (input valid, input matrix_size, output ready);
endinterface

### rtl/core/latin_square_checker_top.sv
`timescale 1ns / 1ps

// Latin-square checker. Cells of a square matrix arrive on in_ch in row-major
// order, one cell per transfer; the side length is the matrix_size register,
// written through cfg_ch (always ready, reset value 4).
// After the last cell of a matrix one result transfer on out_ch carries the
// diagonal sum and the counts of rows and columns holding a repeated value;
// the next matrix then starts from zero.
// Throughput: one cell per cycle; the last cell runs through the cell register
// and update stage to the result register. The cell register reads the column
// bitmap memory (one read, one write per cycle, write data forwarded to the
// read); the update stage does the bitmap test and counters and writes it back.
// Reset clears the positions, counters and result valid; column bitmaps need
// no clearing since the first row of a matrix overwrites them.
// While out_ch stalls with a result waiting, cells that finish no matrix keep
// flowing; only the last cell of the next matrix waits, holding in_ch ready low.

module latin_square_checker_top #(
  parameter int MAX_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lsc_in_if.sink     in_ch,
  lsc_out_if.source  out_ch,
  lsc_cfg_if.sink    cfg_ch
);
  import lsc_pkg::*;

  localparam int PW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SZW = (PW + 1 > SIZE_W) ? PW + 1 : SIZE_W;

  size_t              matrix_size_r;
  logic [PW-1:0]      col_pos_r, col_pos_nxt;
  logic [PW-1:0]      row_pos_r, row_pos_nxt;
  logic [SZW-1:0]     eff_size;
  logic [SZW-1:0]     size_raw;
  cell_ctl_t          ctl_nxt;
  logic               in_xfer;

  logic               s1_valid_r;
  cell_ctl_t          s1_ctl_r;
  cell_t              s1_cell_r;
  logic [PW-1:0]      s1_col_r;
  bitmap_t            col_rd_r;
  logic               s1_adv;

  bitmap_t            col_mem [MAX_SIZE];
  logic [MAX_SIZE-1:0] col_rep_r;

  bitmap_t            row_seen_r;
  logic               row_rep_r;
  trace_t             trace_r, trace_nxt;
  count_t             rows_bad_r, rows_bad_nxt;
  count_t             cols_bad_r, cols_bad_nxt;

  logic [BIT_IDX_W-1:0] bit_idx;
  bitmap_t            bit_vec, rs, cs, col_wdata;
  logic               rrep, crep;

  logic               out_valid_r;
  trace_t             out_trace_r;
  count_t             out_rows_r, out_cols_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= SIZE_RESET;
    end else if (cfg_ch.valid) begin
      matrix_size_r <= cfg_ch.matrix_size;
    end
  end

  // position tracking at the input
  always_comb begin
    size_raw = SZW'(matrix_size_r);
    if (size_raw == '0) begin
      eff_size = SZW'(1);
    end else if (size_raw > SZW'(MAX_SIZE)) begin
      eff_size = SZW'(MAX_SIZE);
    end else begin
      eff_size = size_raw;
    end
    ctl_nxt.first_row = (row_pos_r == '0);
    ctl_nxt.first_col = (col_pos_r == '0);
    ctl_nxt.on_diag   = (row_pos_r == col_pos_r);
    ctl_nxt.last_row  = (SZW'(row_pos_r) + SZW'(1) >= eff_size);
    ctl_nxt.end_row   = (SZW'(col_pos_r) + SZW'(1) >= eff_size);
    ctl_nxt.end_mat   = ctl_nxt.end_row && ctl_nxt.last_row;
    col_pos_nxt = ctl_nxt.end_row ? '0 : col_pos_r + PW'(1);
    if (ctl_nxt.end_mat) begin
      row_pos_nxt = '0;
    end else if (ctl_nxt.end_row) begin
      row_pos_nxt = row_pos_r + PW'(1);
    end else begin
      row_pos_nxt = row_pos_r;
    end
  end

  assign s1_adv      = s1_valid_r && (!s1_ctl_r.end_mat || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_pos_r <= col_pos_nxt;
        row_pos_r <= row_pos_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ctl_r  <= ctl_nxt;
      s1_cell_r <= in_ch.cell_value;
      s1_col_r  <= col_pos_r;
      if (s1_adv && (s1_col_r == col_pos_r)) begin
        col_rd_r <= col_wdata;
      end else begin
        col_rd_r <= col_mem[col_pos_r];
      end
    end
  end

  // bitmap test and counter update
  always_comb begin
    bit_idx      = s1_cell_r[BIT_IDX_W-1:0] - BIT_IDX_W'(1);
    bit_vec      = BITMAP_W'(1) << bit_idx;
    rs           = s1_ctl_r.first_col ? '0 : row_seen_r;
    rrep         = (!s1_ctl_r.first_col && row_rep_r) || ((rs & bit_vec) != '0);
    cs           = s1_ctl_r.first_row ? '0 : col_rd_r;
    crep         = (!s1_ctl_r.first_row && col_rep_r[s1_col_r]) || ((cs & bit_vec) != '0);
    col_wdata    = cs | bit_vec;
    trace_nxt    = trace_r + (s1_ctl_r.on_diag ? TRACE_W'(s1_cell_r) : '0);
    rows_bad_nxt = rows_bad_r + COUNT_W'(s1_ctl_r.end_row && rrep);
    cols_bad_nxt = cols_bad_r + COUNT_W'(s1_ctl_r.last_row && crep);
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      col_mem[s1_col_r] <= col_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_rep_r  <= '0;
      row_seen_r <= '0;
      row_rep_r  <= 1'b0;
      trace_r    <= '0;
      rows_bad_r <= '0;
      cols_bad_r <= '0;
    end else if (s1_adv) begin
      col_rep_r[s1_col_r] <= crep;
      if (s1_ctl_r.end_mat) begin
        row_seen_r <= '0;
        row_rep_r  <= 1'b0;
        trace_r    <= '0;
        rows_bad_r <= '0;
        cols_bad_r <= '0;
      end else begin
        row_seen_r <= rs | bit_vec;
        row_rep_r  <= rrep;
        trace_r    <= trace_nxt;
        rows_bad_r <= rows_bad_nxt;
        cols_bad_r <= cols_bad_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_ctl_r.end_mat) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl_r.end_mat) begin
      out_trace_r <= trace_nxt;
      out_rows_r  <= rows_bad_nxt;
      out_cols_r  <= cols_bad_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.trace_sum        = out_trace_r;
  assign out_ch.bad_row_count    = out_rows_r;
  assign out_ch.bad_column_count = out_cols_r;

endmodule

### rtl/core/lsc_checker.sv
`timescale 1ns / 1ps

module lsc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input lsc_pkg::trace_t       out_trace,
  input lsc_pkg::count_t       out_rows,
  input lsc_pkg::count_t       out_cols,
  input logic                  cfg_ready
);
  import lsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_trace) && $stable(out_rows) && $stable(out_cols))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n) && $past(rst_n, 2) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding cell transfer");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind latin_square_checker_top lsc_checker u_lsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_trace (out_ch.trace_sum),
  .out_rows  (out_ch.bad_row_count),
  .out_cols  (out_ch.bad_column_count),
  .cfg_ready (cfg_ch.ready)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lsc_pkg::*;

  localparam int MAX_SIZE      = 64;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_CELLS  = 1150;

  typedef enum logic [1:0] {
    FEED_CELL,
    FEED_SIZE,
    FEED_PAUSE
  } feed_kind_t;

  typedef struct {
    feed_kind_t kind;
    cell_t      value;
    size_t      size;
  } feed_item_t;

  typedef struct {
    trace_t trace_sum;
    count_t bad_rows;
    count_t bad_cols;
  } matrix_verdict_t;

  logic clk;
  logic rst_n;

  lsc_in_if  in_if ();
  lsc_out_if out_if ();
  lsc_cfg_if cfg_if ();

  latin_square_checker_top #(
    .MAX_SIZE(MAX_SIZE)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  feed_item_t      cell_feed_q[$];
  matrix_verdict_t verdict_q[$];
  int unsigned     cells_queued;
  int unsigned     fail_count;
  logic            all_delivered;

  // shadow of the checker state
  size_t       size_reg_m;
  bitmap_t     col_seen_m [MAX_SIZE];
  bit          col_dup_m [MAX_SIZE];
  bitmap_t     row_seen_m;
  bit          row_dup_m;
  int unsigned row_at;
  int unsigned col_at;
  trace_t      trace_acc;
  count_t      rows_bad_acc;
  count_t      cols_bad_acc;

  function automatic int unsigned clamp_size(size_t s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return 32'(s);
  endfunction

  task automatic open_matrix();
    row_seen_m   = '0;
    row_dup_m    = 1'b0;
    row_at       = 0;
    col_at       = 0;
    trace_acc    = '0;
    rows_bad_acc = '0;
    cols_bad_acc = '0;
  endtask

  task automatic score_cell(input cell_t v);
    int unsigned     side;
    int unsigned     col;
    bitmap_t         hit;
    bitmap_t         rs;
    bitmap_t         cs;
    bit              rdup;
    bit              cdup;
    bit              row_done;
    bit              last_row;
    matrix_verdict_t verdict;
    side = clamp_size(size_reg_m);
    // bit index wraps modulo 64, so 0 lands on 64 and 65..127 on 1..63
    hit = bitmap_t'(1) << BIT_IDX_W'(v - 1'b1);
    col = (col_at >= MAX_SIZE) ? MAX_SIZE - 1 : col_at;

    rs   = (col == 0) ? '0 : row_seen_m;
    rdup = (col == 0) ? 1'b0 : row_dup_m;
    if ((rs & hit) != 0) rdup = 1'b1;
    row_seen_m = rs | hit;
    row_dup_m  = rdup;

    cs   = (row_at == 0) ? '0 : col_seen_m[col];
    cdup = (row_at == 0) ? 1'b0 : col_dup_m[col];
    if ((cs & hit) != 0) cdup = 1'b1;
    col_seen_m[col] = cs | hit;
    col_dup_m[col]  = cdup;

    if (row_at == col) trace_acc = trace_acc + TRACE_W'(v);

    row_done = (col + 1 >= side);
    last_row = (row_at + 1 >= side);
    if (last_row && cdup) cols_bad_acc = cols_bad_acc + 1'b1;

    if (row_done) begin
      if (rdup) rows_bad_acc = rows_bad_acc + 1'b1;
      col_at = 0;
      row_at = row_at + 1;
    end else begin
      col_at = col + 1;
    end

    if (row_done && last_row) begin
      verdict.trace_sum = trace_acc;
      verdict.bad_rows  = rows_bad_acc;
      verdict.bad_cols  = cols_bad_acc;
      verdict_q = {verdict_q, verdict};
      open_matrix();
    end
  endtask

  task automatic queue_cell(input int unsigned v);
    feed_item_t item;
    item.kind  = FEED_CELL;
    item.value = cell_t'(v);
    item.size  = '0;
    cell_feed_q = {cell_feed_q, item};
    cells_queued++;
  endtask

  task automatic queue_size(input int unsigned s);
    feed_item_t item;
    item.kind  = FEED_SIZE;
    item.value = '0;
    item.size  = size_t'(s);
    cell_feed_q = {cell_feed_q, item};
  endtask

  task automatic queue_pause();
    feed_item_t item;
    item.kind  = FEED_PAUSE;
    item.value = '0;
    item.size  = '0;
    cell_feed_q = {cell_feed_q, item};
  endtask

  // shrink_row != 0: the size is rewritten to shrink_to at the start of that row
  task automatic queue_matrix(input int unsigned side, input int unsigned shrink_row,
                              input int unsigned shrink_to);
    int unsigned style;
    int unsigned off;
    int unsigned base;
    int unsigned bad_r;
    int unsigned bad_c;
    int unsigned rows;
    int unsigned cols;
    int unsigned v;
    style = $urandom_range(99, 0);
    off   = $urandom_range(63, 0);
    base  = $urandom_range(65 - side, 1);
    bad_r = $urandom_range(side - 1, 0);
    bad_c = $urandom_range(side - 1, 0);
    rows  = side;
    cols  = side;
    for (int unsigned r = 0; r < rows; r++) begin
      if (shrink_row != 0 && r == shrink_row) begin
        queue_size(shrink_to);
        cols = clamp_size(size_t'(shrink_to));
        rows = (r + 1 >= cols) ? r + 1 : cols;
      end
      for (int unsigned c = 0; c < cols; c++) begin
        if (style < 60) begin
          v = (r + c + off) % cols + base;
          if (style >= 45 && r == bad_r && c == bad_c) v = $urandom_range(64, 1);
        end else if (style < 85) begin
          v = $urandom_range(cols, 1);
        end else begin
          v = $urandom_range(127, 0);
        end
        queue_cell(v);
      end
    end
  endtask

  // sender
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  always @(posedge clk) begin : feeder
    bit in_fire;
    bit cfg_fire;
    in_fire  = in_if.valid && in_if.ready;
    cfg_fire = cfg_if.valid && cfg_if.ready;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      cfg_if.valid <= 1'b0;
      gap_left     <= 0;
      burst_left   <= 0;
      quiet_cycles <= 0;
    end else begin
      if (in_fire || cfg_fire) void'(cell_feed_q.pop_front());
      if (cfg_fire) cfg_if.valid <= 1'b0;
      if (in_if.valid && !in_fire) begin
        // offered cell still waiting for its transfer
      end else if (cell_feed_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (cell_feed_q[0].kind == FEED_CELL) begin
        if (gap_left > 0) begin
          in_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else begin
          in_if.valid      <= 1'b1;
          in_if.cell_value <= cell_feed_q[0].value;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(24, 0);
            gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end else begin
        // size writes and pauses wait for an idle block
        in_if.valid <= 1'b0;
        if (in_fire || cfg_fire || cfg_if.valid || !all_delivered) begin
          quiet_cycles <= 0;
        end else if (quiet_cycles < SETTLE_CYCLES) begin
          quiet_cycles <= quiet_cycles + 1;
        end else if (cell_feed_q[0].kind == FEED_PAUSE) begin
          void'(cell_feed_q.pop_front());
          quiet_cycles <= 0;
        end else begin
          cfg_if.valid       <= 1'b1;
          cfg_if.matrix_size <= cell_feed_q[0].size;
          quiet_cycles       <= 0;
        end
      end
    end
  end

  // receiver stall pattern
  logic [7:0] stall_phase;

  always @(posedge clk) begin : sink_pattern
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_phase  <= '0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[7:6])
        2'd0: begin
          out_if.ready <= 1'b1;
        end
        2'd1: begin
          out_if.ready <= 1'($urandom_range(1, 0));
        end
        2'd2: begin
          out_if.ready <= (stall_phase[2:0] == 3'd7);
        end
        default: begin
          out_if.ready <= stall_phase[4];
        end
      endcase
    end
  end

  // monitor, predictor and watchdog
  int unsigned idle_cycles;

  always @(posedge clk) begin : monitor
    matrix_verdict_t want;
    if (!rst_n) begin
      size_reg_m = SIZE_RESET;
      foreach (col_seen_m[i]) begin
        col_seen_m[i] = '0;
        col_dup_m[i]  = 1'b0;
      end
      open_matrix();
      verdict_q.delete();
      idle_cycles = 0;
      all_delivered <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transfer: trace_sum %0d", out_if.trace_sum);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_if.trace_sum !== want.trace_sum) begin
            $error("trace_sum: expected %0d, actual %0d", want.trace_sum, out_if.trace_sum);
            fail_count++;
          end
          if (out_if.bad_row_count !== want.bad_rows) begin
            $error("bad_row_count: expected %0d, actual %0d", want.bad_rows,
                   out_if.bad_row_count);
            fail_count++;
          end
          if (out_if.bad_column_count !== want.bad_cols) begin
            $error("bad_column_count: expected %0d, actual %0d", want.bad_cols,
                   out_if.bad_column_count);
            fail_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) size_reg_m = cfg_if.matrix_size;
      if (in_if.valid && in_if.ready) score_cell(in_if.cell_value);
      all_delivered <= (verdict_q.size() == 0);

      if ((out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (in_if.valid && in_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned cur_size;
    int unsigned side;
    int unsigned pick;
    int unsigned shrink_to;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cell_value   = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.matrix_size = '0;
    out_if.ready       = 1'b0;
    cells_queued       = 0;
    fail_count         = 0;

    // single cells: largest value, size 0 acting as 1, values 0 and 127
    queue_size(1);
    queue_cell(64);
    queue_size(0);
    queue_cell(0);
    queue_cell(127);
    // 2x2: all repeats, then aliased repeats (0 ~ 64, 65 ~ 1)
    queue_size(2);
    repeat (4) queue_cell(1);
    queue_cell(1);
    queue_cell(65);
    queue_cell(64);
    queue_cell(0);
    // shrink from 3 to 2 inside the second row
    queue_size(3);
    queue_cell(1);
    queue_cell(2);
    queue_cell(3);
    queue_cell(2);
    queue_size(2);
    queue_cell(3);
    // grow from 2 to 3 inside the first row
    queue_size(2);
    queue_cell(1);
    queue_size(3);
    queue_cell(2);
    queue_cell(3);
    queue_cell(2);
    queue_cell(3);
    queue_cell(1);
    queue_cell(3);
    queue_cell(1);
    queue_cell(2);
    cur_size = 3;

    queue_pause();
    while (cells_queued < RANDOM_CELLS) begin
      if ($urandom_range(99, 0) < 5) queue_pause();
      pick = $urandom_range(99, 0);
      if (pick < 6) begin
        // oversized setting acts as the largest side; shrunk after the first row
        queue_size($urandom_range(127, 65));
        shrink_to = $urandom_range(6, 0);
        queue_matrix(MAX_SIZE, 1, shrink_to);
        cur_size = shrink_to;
      end else begin
        if (pick < 50) begin
          pick = $urandom_range(99, 0);
          if (pick < 80) cur_size = $urandom_range(8, 1);
          else if (pick < 94) cur_size = $urandom_range(16, 9);
          else cur_size = 0;
          queue_size(cur_size);
        end
        side = clamp_size(size_t'(cur_size));
        if (side >= 2 && $urandom_range(9, 0) == 0) begin
          shrink_to = $urandom_range(side, 0);
          queue_matrix(side, $urandom_range(side - 1, 1), shrink_to);
          cur_size = shrink_to;
        end else begin
          queue_matrix(side, 0, 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (cell_feed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!all_delivered) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
